[design/i2cbm_pkg.sv]
// Shared types and constants for the I2C bit-level master.
package i2cbm_pkg;

    localparam int unsigned DelayWidth = 16;
    localparam logic [DelayWidth-1:0] DelayReset = 16'd100;

    typedef enum logic [2:0] {
        CMD_NONE     = 3'd0,
        CMD_START    = 3'd1,
        CMD_STOP     = 3'd2,
        CMD_WRITE    = 3'd3,
        CMD_READ     = 3'd4,
        CMD_GET_ACK  = 3'd5,
        CMD_SEND_ACK = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LOW  = 2'd1,
        PH_DATA = 2'd2,
        PH_HIGH = 2'd3
    } phase_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] write_data;
        logic       ack_level;
        logic       sda_in;
    } tick_t;

    typedef struct packed {
        logic       rejected;
        logic       ack_seen;
        logic [7:0] read_data;
        logic       done_res;
        logic       busy_res;
        logic       sda_out;
        logic       scl_out;
    } result_t;

endpackage

[design/i2cbm_seq.sv]
// Line sequencer: state registers and per-tick next-state logic.
module i2cbm_seq import i2cbm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  tick_t                 tick,
    input  logic [DelayWidth-1:0] delay_ticks,
    output result_t               result
);

    cmd_t                  act_reg, act_next;
    phase_t                phase_reg, phase_next;
    logic [3:0]            bit_count_reg, bit_count_next;
    logic [DelayWidth-1:0] wait_reg, wait_next;
    logic [7:0]            shift_reg, shift_next;
    logic                  scl_reg, scl_next;
    logic                  sda_reg, sda_next;
    logic                  ack_reg, ack_next;
    logic [7:0]            last_read_reg, last_read_next;
    logic                  done, rej;
    logic [DelayWidth-1:0] gap;
    logic                  cmd_valid;
    logic                  byte_cmd;
    logic [3:0]            bits_done;

    assign gap       = (delay_ticks == '0) ? {{(DelayWidth-1){1'b0}}, 1'b1} : delay_ticks;
    assign cmd_valid = (tick.cmd >= CMD_START) && (tick.cmd <= CMD_SEND_ACK);
    assign byte_cmd  = (act_reg == CMD_WRITE) || (act_reg == CMD_READ);
    assign bits_done = bit_count_reg + 4'd1;

    // next state
    always_comb begin
        act_next       = act_reg;
        phase_next     = phase_reg;
        bit_count_next = bit_count_reg;
        wait_next      = wait_reg;
        shift_next     = shift_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        ack_next       = ack_reg;
        last_read_next = last_read_reg;
        done           = 1'b0;
        rej            = 1'b0;
        if (step) begin
            if (act_reg == CMD_NONE) begin
                if (cmd_valid) begin
                    act_next       = cmd_t'(tick.cmd);
                    bit_count_next = 4'd0;
                    case (tick.cmd)
                        CMD_WRITE:    shift_next = tick.write_data;
                        CMD_SEND_ACK: shift_next = {tick.ack_level, 7'd0};
                        CMD_READ:     shift_next = 8'd0;
                        default:      shift_next = shift_reg;
                    endcase
                    scl_next = 1'b0;
                    if (tick.cmd == CMD_STOP) begin
                        sda_next = 1'b0;
                    end
                    phase_next = PH_LOW;
                    wait_next  = gap;
                end
            end else begin
                rej = cmd_valid;
                if (wait_reg > {{(DelayWidth-1){1'b0}}, 1'b1}) begin
                    wait_next = wait_reg - {{(DelayWidth-1){1'b0}}, 1'b1};
                end else if (act_reg == CMD_START) begin
                    if (phase_reg == PH_LOW) begin
                        sda_next   = 1'b1;
                        scl_next   = 1'b1;
                        phase_next = PH_DATA;
                        wait_next  = gap;
                    end else begin
                        sda_next = 1'b0;
                        done     = 1'b1;
                    end
                end else if (act_reg == CMD_STOP) begin
                    if (phase_reg == PH_LOW) begin
                        scl_next   = 1'b1;
                        phase_next = PH_DATA;
                        wait_next  = {{(DelayWidth-1){1'b0}}, 1'b1};
                    end else begin
                        sda_next = 1'b1;
                        done     = 1'b1;
                    end
                end else begin
                    case (phase_reg)
                        PH_LOW: begin
                            if (act_reg == CMD_WRITE || act_reg == CMD_SEND_ACK) begin
                                sda_next   = shift_reg[7];
                                shift_next = {shift_reg[6:0], 1'b0};
                            end else begin
                                sda_next = 1'b1;
                            end
                            phase_next = PH_DATA;
                            wait_next  = gap;
                        end
                        PH_DATA: begin
                            scl_next   = 1'b1;
                            phase_next = PH_HIGH;
                            wait_next  = gap;
                        end
                        default: begin
                            if (act_reg == CMD_READ) begin
                                shift_next = {shift_reg[6:0], tick.sda_in};
                            end
                            if (act_reg == CMD_GET_ACK) begin
                                ack_next = tick.sda_in;
                            end
                            bit_count_next = bits_done;
                            if (bits_done < (byte_cmd ? 4'd8 : 4'd1)) begin
                                scl_next   = 1'b0;
                                phase_next = PH_LOW;
                                wait_next  = gap;
                            end else begin
                                if (act_reg == CMD_READ) begin
                                    last_read_next = {shift_reg[6:0], tick.sda_in};
                                end
                                done = 1'b1;
                            end
                        end
                    endcase
                end
                if (done) begin
                    act_next   = CMD_NONE;
                    phase_next = PH_IDLE;
                    wait_next  = '0;
                end
            end
        end
    end

    // outputs
    always_comb begin
        result.scl_out   = scl_next;
        result.sda_out   = sda_next;
        result.busy_res  = (act_next != CMD_NONE);
        result.done_res  = done;
        result.read_data = last_read_next;
        result.ack_seen  = ack_next;
        result.rejected  = rej;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg       <= CMD_NONE;
            phase_reg     <= PH_IDLE;
            bit_count_reg <= 4'd0;
            wait_reg      <= '0;
            shift_reg     <= 8'd0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            ack_reg       <= 1'b1;
            last_read_reg <= 8'd0;
        end else begin
            act_reg       <= act_next;
            phase_reg     <= phase_next;
            bit_count_reg <= bit_count_next;
            wait_reg      <= wait_next;
            shift_reg     <= shift_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            ack_reg       <= ack_next;
            last_read_reg <= last_read_next;
        end
    end

endmodule

[design/i2c_bit_level_master.sv]
// Top level of the I2C bit-level master: tick register, sequencer, result register.
// Usage:
//   s_ channel: one word per bus tick; tdata carries cmd, write_data, ack_level,
//     sda_in. A word with cmd none still advances the sequencer by one tick.
//   m_ channel: one result word per input word, same order; tdata carries the SCL
//     and SDA drive levels, busy, done, read byte, ack level and rejected flag.
//   cfg channel: writes delay_ticks (ticks per bus delay, 0 acts as 1); always
//     ready. The user must write delay_ticks only while the block is idle; the
//     block itself does not enforce this.
// The word is registered in the tick register, then the sequencer result is
// captured in the result register, which drives m_tvalid. Throughput is one word
// per cycle while m_tready is high; the sequencer state advances once per word.
// Reset clears both stages, releases SCL and SDA, sets the ack level to 1 and
// delay_ticks to 100. When m_tready is low the result register holds, the tick
// register fills, and s_tready then drops until the result is taken.
module i2c_bit_level_master import i2cbm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // cmd[2:0], write_data[10:3], ack_level[11], sda_in[12]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // scl_out, sda_out, busy_res, done_res,
                                   // read_data[11:4], ack_seen[12], rejected[13]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic                  in_valid_reg, in_valid_next;
    tick_t                 in_data_reg;
    logic                  out_valid_reg, out_valid_next;
    result_t               out_data_reg;
    logic [DelayWidth-1:0] delay_reg;
    logic                  out_free, step, s_take;
    result_t               result;

    assign out_free  = !out_valid_reg || m_tready;
    assign step      = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign s_take    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign in_valid_next  = s_take ? 1'b1 : (step ? 1'b0 : in_valid_reg);
    assign out_valid_next = step ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    i2cbm_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .tick        (in_data_reg),
        .delay_ticks (delay_reg),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            delay_reg     <= DelayReset;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                delay_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_data_reg.cmd        <= s_tdata[2:0];
            in_data_reg.write_data <= s_tdata[10:3];
            in_data_reg.ack_level  <= s_tdata[11];
            in_data_reg.sda_in     <= s_tdata[12];
        end
        if (step) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg};

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        step && result.done_res |-> !result.busy_res)
        else $error("done reported while still busy");

    a_take_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s_take |-> (!in_valid_reg || step))
        else $error("tick register overwritten");

    a_step_out: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> out_valid_reg)
        else $error("result lost after sequencer step");

endmodule

[verif/tb_i2c_bit_level_master.sv]
// Self-checking testbench for the I2C bit-level master: directed and random tick streams.
module tb_i2c_bit_level_master;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cbm_pkg::*;

    localparam logic [2:0] CmdUnused = 3'd7;
    localparam logic [15:0] DelayLong = 16'h0100;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    result_t pending_lines[$];
    int      mismatches = 0;
    int      ticks_sent = 0;
    int      hold_cycles = 0;
    int      stray_rate = 0;
    bit      send_idle_on = 1'b0;
    bit      recv_idle_on = 1'b0;

    // Sequencer state as predicted from the accepted words
    cmd_t        seq_cmd       = CMD_NONE;
    phase_t      seq_phase     = PH_IDLE;
    logic [3:0]  seq_bits      = '0;
    logic [15:0] seq_wait      = '0;
    logic [15:0] seq_delay     = DelayReset;
    logic [7:0]  seq_shift     = '0;
    logic [7:0]  seq_last_read = '0;
    logic        seq_scl       = 1'b1;
    logic        seq_sda       = 1'b1;
    logic        seq_ack       = 1'b1;

    i2c_bit_level_master DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // cmd[2:0], write_data[10:3], ack_level[11], sda_in[12]
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // scl_out, sda_out, busy_res, done_res,
                                // read_data[11:4], ack_seen[12], rejected[13]
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic logic [15:0] bus_gap();
        return (seq_delay == 16'd0) ? 16'd1 : seq_delay;
    endfunction

    function automatic result_t step_sequencer(tick_t t);
        result_t    r;
        logic       is_cmd;
        logic       done;
        logic [3:0] nbits;
        is_cmd = (t.cmd >= CMD_START) && (t.cmd <= CMD_SEND_ACK);
        done   = 1'b0;
        r      = '0;
        if (seq_cmd == CMD_NONE) begin
            if (is_cmd) begin
                seq_cmd  = cmd_t'(t.cmd);
                seq_bits = '0;
                case (seq_cmd)
                    CMD_WRITE:    seq_shift = t.write_data;
                    CMD_SEND_ACK: seq_shift = {t.ack_level, 7'd0};
                    CMD_READ:     seq_shift = 8'd0;
                    default: ;
                endcase
                seq_scl = 1'b0;
                if (seq_cmd == CMD_STOP) seq_sda = 1'b0;
                seq_phase = PH_LOW;
                seq_wait  = bus_gap();
            end
        end else begin
            r.rejected = is_cmd;
            if (seq_wait > 16'd1) begin
                seq_wait = seq_wait - 16'd1;
            end else if (seq_cmd == CMD_START) begin
                if (seq_phase == PH_LOW) begin
                    seq_sda   = 1'b1;
                    seq_scl   = 1'b1;
                    seq_phase = PH_DATA;
                    seq_wait  = bus_gap();
                end else begin
                    seq_sda = 1'b0;
                    done    = 1'b1;
                end
            end else if (seq_cmd == CMD_STOP) begin
                // SDA rises one tick after SCL
                if (seq_phase == PH_LOW) begin
                    seq_scl   = 1'b1;
                    seq_phase = PH_DATA;
                    seq_wait  = 16'd1;
                end else begin
                    seq_sda = 1'b1;
                    done    = 1'b1;
                end
            end else if (seq_phase == PH_LOW) begin
                if (seq_cmd == CMD_WRITE || seq_cmd == CMD_SEND_ACK) begin
                    seq_sda   = seq_shift[7];
                    seq_shift = {seq_shift[6:0], 1'b0};
                end else begin
                    seq_sda = 1'b1;
                end
                seq_phase = PH_DATA;
                seq_wait  = bus_gap();
            end else if (seq_phase == PH_DATA) begin
                seq_scl   = 1'b1;
                seq_phase = PH_HIGH;
                seq_wait  = bus_gap();
            end else begin
                nbits = (seq_cmd == CMD_WRITE || seq_cmd == CMD_READ) ? 4'd8 : 4'd1;
                if (seq_cmd == CMD_READ) seq_shift = {seq_shift[6:0], t.sda_in};
                if (seq_cmd == CMD_GET_ACK) seq_ack = t.sda_in;
                seq_bits = seq_bits + 4'd1;
                if (seq_bits < nbits) begin
                    seq_scl   = 1'b0;
                    seq_phase = PH_LOW;
                    seq_wait  = bus_gap();
                end else begin
                    if (seq_cmd == CMD_READ) seq_last_read = seq_shift;
                    done = 1'b1;
                end
            end
            if (done) begin
                seq_cmd   = CMD_NONE;
                seq_phase = PH_IDLE;
                seq_wait  = '0;
            end
        end
        r.scl_out   = seq_scl;
        r.sda_out   = seq_sda;
        r.busy_res  = (seq_cmd != CMD_NONE);
        r.done_res  = done;
        r.read_data = seq_last_read;
        r.ack_seen  = seq_ack;
        return r;
    endfunction

    function automatic logic sda_for(int sel);
        return (sel > 1) ? 1'($urandom) : 1'(sel);
    endfunction

    // Entered and left at a falling edge; tvalid stays high on return.
    task automatic send_tick(logic [2:0] c, logic [7:0] wd, logic al, logic sd);
        if (send_idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, sd, al, wd, c};
        do @(posedge aclk); while (!s_tready);
        pending_lines.push_back(step_sequencer('{cmd: c, write_data: wd, ack_level: al,
                                                 sda_in: sd}));
        ticks_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_lines.size() != 0);
    endtask

    task automatic finish_sequence();
        while (seq_cmd != CMD_NONE) send_tick(CMD_NONE, 8'($urandom), 1'($urandom),
                                              1'($urandom));
        drain_results();
    endtask

    task automatic write_delay(logic [15:0] v);
        finish_sequence();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        seq_delay = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_command(logic [2:0] c, logic [7:0] wd, logic al, int sd_sel);
        logic [2:0] extra;
        send_tick(c, wd, al, sda_for(sd_sel));
        while (seq_cmd != CMD_NONE) begin
            extra = CMD_NONE;
            if (stray_rate != 0 && $urandom_range(1, stray_rate) == 1)
                extra = 3'($urandom_range(CMD_START, CmdUnused));
            send_tick(extra, 8'($urandom), 1'($urandom), sda_for(sd_sel));
        end
    endtask

    task automatic test_reset_value();
        run_command(CMD_START, 8'h00, 1'b0, 2);
        run_command(CMD_STOP, 8'hFF, 1'b1, 2);
    endtask

    task automatic test_zero_delay();
        write_delay(16'd0);
        for (int i = CMD_START; i <= CMD_SEND_ACK; i++)
            run_command(3'(i), 8'($urandom), 1'($urandom), 2);
    endtask

    task automatic test_each_command();
        write_delay(16'd1);
        run_command(CMD_START, 8'h00, 1'b0, 1);
        run_command(CMD_WRITE, 8'h00, 1'b0, 0);
        run_command(CMD_WRITE, 8'hFF, 1'b1, 1);
        run_command(CMD_WRITE, 8'hA5, 1'b0, 2);
        run_command(CMD_READ, 8'h00, 1'b0, 1);
        run_command(CMD_READ, 8'hFF, 1'b1, 0);
        run_command(CMD_READ, 8'h5A, 1'b0, 2);
        run_command(CMD_GET_ACK, 8'h00, 1'b0, 0);
        run_command(CMD_GET_ACK, 8'h00, 1'b1, 1);
        run_command(CMD_SEND_ACK, 8'hFF, 1'b0, 2);
        run_command(CMD_SEND_ACK, 8'h00, 1'b1, 2);
        run_command(CMD_STOP, 8'h00, 1'b0, 2);
    endtask

    task automatic test_busy_reject();
        logic [2:0] code;
        write_delay(16'd2);
        code = CMD_START;
        send_tick(CMD_WRITE, 8'h5A, 1'b0, 1'b0);
        // every code lands on a busy tick, including the completing one
        while (seq_cmd != CMD_NONE) begin
            send_tick(code, ~8'h5A, 1'($urandom), 1'($urandom));
            code = (code == CmdUnused) ? CMD_START : code + 3'd1;
        end
        run_command(CMD_START, 8'h00, 1'b0, 2);
    endtask

    task automatic test_unused_code();
        repeat (3) send_tick(CmdUnused, 8'($urandom), 1'($urandom), 1'($urandom));
        send_tick(CMD_NONE, 8'hFF, 1'b1, 1'b1);
        run_command(CMD_GET_ACK, 8'h00, 1'b0, 2);
    endtask

    task automatic test_long_delay();
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        write_delay(DelayLong);
        run_command(CMD_STOP, 8'h00, 1'b0, 2);
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
    endtask

    task automatic test_output_stall();
        write_delay(16'd2);
        send_idle_on = 1'b0;
        hold_cycles  = 300;
        run_command(CMD_READ, 8'h00, 1'b0, 2);
        send_idle_on = 1'b1;
    endtask

    task automatic test_sender_pause();
        write_delay(16'd3);
        send_tick(CMD_WRITE, 8'h3C, 1'b0, 1'b1);
        repeat (4) send_tick(CMD_NONE, 8'($urandom), 1'($urandom), 1'($urandom));
        drain_results();
        finish_sequence();
    endtask

    task automatic test_random_traffic();
        int first_tick;
        first_tick = ticks_sent;
        stray_rate = 12;
        while (ticks_sent - first_tick < 150) begin
            write_delay(($urandom_range(0, 3) == 0) ? 16'($urandom_range(4, 8))
                                                     : 16'($urandom_range(0, 2)));
            send_idle_on = ($urandom_range(0, 3) != 0);
            recv_idle_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(3, 8)) begin
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 4))
                        send_tick(($urandom_range(0, 1) != 0) ? CmdUnused : CMD_NONE,
                                  8'($urandom), 1'($urandom), 1'($urandom));
                run_command(3'($urandom_range(CMD_START, CMD_SEND_ACK)), 8'($urandom),
                            1'($urandom), 2);
            end
        end
        stray_rate   = 0;
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
    endtask

    task automatic test_full_rate();
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        stray_rate   = 10;
        write_delay(16'd1);
        repeat (6)
            run_command(3'($urandom_range(CMD_START, CMD_SEND_ACK)), 8'($urandom),
                        1'($urandom), 2);
        stray_rate = 0;
    endtask

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[13:0]);
            if (pending_lines.size() == 0) begin
                $display("%0t unexpected word: expected none actual %h", $time, m_tdata);
                mismatches++;
            end else begin
                want = pending_lines.pop_front();
                check_field("scl_out", 8'(want.scl_out), 8'(got.scl_out));
                check_field("sda_out", 8'(want.sda_out), 8'(got.sda_out));
                check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
                check_field("done_res", 8'(want.done_res), 8'(got.done_res));
                check_field("read_data", want.read_data, got.read_data);
                check_field("ack_seen", 8'(want.ack_seen), 8'(got.ack_seen));
                check_field("rejected", 8'(want.rejected), 8'(got.rejected));
            end
        end
    end

    // Result-side backpressure: random bursts plus an occasional long hold
    initial begin
        int burst_left;
        burst_left = 0;
        m_tready   = 1'b1;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else if (!recv_idle_on) begin
                m_tready <= 1'b1;
            end else if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(1, 16) - 1;
                m_tready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    initial begin
        #(20_000_000);
        $display("tb_i2c_bit_level_master failed");
        $finish;
    end

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;

        test_reset_value();
        test_zero_delay();
        test_each_command();
        test_busy_reject();
        test_unused_code();
        test_long_delay();
        test_output_stall();
        test_sender_pause();
        test_random_traffic();
        test_full_rate();

        drain_results();
        repeat (4) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb_i2c_bit_level_master passed");
        end else begin
            $display("tb_i2c_bit_level_master failed");
        end
        $finish;
    end

endmodule
